@@ src/trht_pkg.sv @@
// Package for the touch region hit table: command codes, event mask bits and beat types.
// No dependencies; used by touch_region_hit_table and by the bench.
package trht_pkg;

   // command codes
   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_SAMPLE = 2'd3;

   // event mask bits
   localparam int EV_START = 0;
   localparam int EV_LIFT  = 1;
   localparam int EV_HELD  = 2;
   localparam int EV_CLICK = 3;

   // input beat
   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] left_x;
      logic [11:0] right_x;
      logic [11:0] top_y;
      logic [11:0] bottom_y;
      logic [3:0]  event_mask;
      logic [4:0]  entry_id;
      logic        pressed;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [11:0] pressure;
   } req_type;

   // result beat
   typedef struct packed {
      logic        status;
      logic [4:0]  alloc_id;
      logic        lift_off;
      logic        click;
      logic [4:0]  old_id;
      logic        touch_start;
      logic        held;
      logic [4:0]  touched_id;
      logic [11:0] event_x;
      logic [11:0] event_y;
      logic [11:0] event_pressure;
   } rsp_type;

endpackage

@@ src/touch_region_hit_table.sv @@
// Touch region hit table: region memory, slot-used bits and a scan sequencer. Uses trht_pkg.
// Free and clear go straight to the output stage and a released sample skips the scan. Allocate
// steps to the lowest free slot; a pressed sample stops at the first hit or after the last
// entry, using the one-entry-per-cycle scan with one shared bounds compare.
// One item at a time; the next item is taken once its beat is loaded into the output
// register, where it waits while the next item runs. Reset clears slot-used, touch, valid.
module touch_region_hit_table #(
   parameter int ENTRIES    = 32,
   parameter int COORD_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  trht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output trht_pkg::rsp_type rsp_data
);
   import trht_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CB    = COORD_BITS;
   localparam int WORD_W = 4 * CB + 4;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ALLOC = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_LAST  = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   // region memory: {left, right, top, bottom, mask}
   logic [WORD_W-1:0] region_mem [ENTRIES];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_addr;
   logic [WORD_W-1:0] mem_wdata;

   // control state
   logic [2:0]       state_ff, state_in;
   logic [ENTRIES-1:0] slot_used_ff, slot_used_in;
   logic             last_valid_ff, last_valid_in;
   logic [IDX_W-1:0] last_entry_ff, last_entry_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             pend_ff, pend_in;
   logic             issued_last_ff, issued_last_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;

   // payload state
   req_type          req_ff, req_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic [3:0]       hit_mask_ff, hit_mask_in;
   logic             now_ff, now_in;

   // fields of the word under compare
   logic [CB-1:0] rd_lx, rd_rx, rd_ty, rd_by, px, py;
   logic [3:0]    rd_mask;
   logic          match, changed, lo, ck, st, hd;

   // id reported in its low 5 bits
   function automatic logic [4:0] id5(input logic [IDX_W-1:0] i);
      logic [IDX_W+4:0] w;
      w = {5'b0, i};
      return w[4:0];
   endfunction

   assign rd_lx   = rd_data_ff[4*CB+3 -: CB];
   assign rd_rx   = rd_data_ff[3*CB+3 -: CB];
   assign rd_ty   = rd_data_ff[2*CB+3 -: CB];
   assign rd_by   = rd_data_ff[CB+3 -: CB];
   assign rd_mask = rd_data_ff[3:0];
   assign px      = CB'(req_ff.pos_x);
   assign py      = CB'(req_ff.pos_y);

   // shared bounds compare against the word read last cycle
   assign match = pend_ff && slot_used_ff[chk_idx_ff] &&
                  (rd_lx <= px) && (rd_rx >= px) && (rd_ty <= py) && (rd_by >= py);

   // event decisions for the finishing sample
   assign changed = (now_ff != last_valid_ff) || (now_ff && (hit_ff != last_entry_ff));
   assign lo = last_valid_ff && changed && rd_mask[EV_LIFT];
   assign ck = last_valid_ff && changed && !now_ff && rd_mask[EV_CLICK];
   assign st = changed && now_ff && hit_mask_ff[EV_START];
   assign hd = now_ff && hit_mask_ff[EV_HELD];

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      slot_used_in   = slot_used_ff;
      last_valid_in  = last_valid_ff;
      last_entry_in  = last_entry_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      pend_in        = pend_ff;
      issued_last_in = issued_last_ff;
      scan_idx_in    = scan_idx_ff;
      req_in         = req_ff;
      res_in         = res_ff;
      rsp_data_in    = rsp_data_ff;
      chk_idx_in     = chk_idx_ff;
      hit_in         = hit_ff;
      hit_mask_in    = hit_mask_ff;
      now_in         = now_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = scan_idx_ff;
      mem_wdata      = {CB'(req_ff.left_x), CB'(req_ff.right_x), CB'(req_ff.top_y),
                        CB'(req_ff.bottom_y), req_ff.event_mask};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in         = req_data;
               res_in         = '0;
               scan_idx_in    = '0;
               pend_in        = 1'b0;
               issued_last_in = 1'b0;
               unique case (req_data.cmd)
                  CMD_ALLOC: begin
                     state_in = S_ALLOC;
                  end
                  CMD_FREE: begin
                     if (32'(req_data.entry_id) < ENTRIES) begin
                        slot_used_in[IDX_W'(req_data.entry_id)] = 1'b0;
                     end
                     state_in = S_OUT;
                  end
                  CMD_CLEAR: begin
                     slot_used_in  = '0;
                     last_valid_in = 1'b0;
                     last_entry_in = '0;
                     state_in      = S_OUT;
                  end
                  CMD_SAMPLE: begin
                     if (req_data.pressed) begin
                        state_in = S_SCAN;
                     end else begin
                        now_in   = 1'b0;
                        state_in = S_LAST;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         // lowest free slot, one slot a cycle
         S_ALLOC: begin
            if (!slot_used_ff[scan_idx_ff]) begin
               mem_we                    = 1'b1;
               slot_used_in[scan_idx_ff] = 1'b1;
               res_in.alloc_id           = id5(scan_idx_ff);
               state_in                  = S_OUT;
            end else if (scan_idx_ff == LAST_IDX) begin
               res_in.status = 1'b1;
               state_in      = S_OUT;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         // read one entry while comparing the previous one
         S_SCAN: begin
            if (match) begin
               now_in      = 1'b1;
               hit_in      = chk_idx_ff;
               hit_mask_in = rd_mask;
               state_in    = S_LAST;
            end else if (pend_ff && (chk_idx_ff == LAST_IDX)) begin
               now_in   = 1'b0;
               state_in = S_LAST;
            end else if (!issued_last_ff) begin
               mem_re         = 1'b1;
               pend_in        = 1'b1;
               chk_idx_in     = scan_idx_ff;
               issued_last_in = (scan_idx_ff == LAST_IDX);
               scan_idx_in    = scan_idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         // fetch the old entry's mask when the touch moved
         S_LAST: begin
            if (changed && last_valid_ff) begin
               mem_re   = 1'b1;
               mem_addr = last_entry_ff;
            end
            state_in = S_FIN;
         end
         // build the sample beat and move the touched entry
         S_FIN: begin
            res_in.lift_off       = lo;
            res_in.click          = ck;
            res_in.old_id         = (lo || ck) ? id5(last_entry_ff) : 5'd0;
            res_in.touch_start    = st;
            res_in.held           = hd;
            res_in.touched_id     = (st || hd) ? id5(hit_ff) : 5'd0;
            res_in.event_x        = st ? req_ff.pos_x : 12'd0;
            res_in.event_y        = st ? req_ff.pos_y : 12'd0;
            res_in.event_pressure = st ? req_ff.pressure : 12'd0;
            last_valid_in         = now_ff;
            last_entry_in         = now_ff ? hit_ff : '0;
            state_in              = S_OUT;
         end
         // hand the beat to the output register
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         slot_used_ff   <= '0;
         last_valid_ff  <= 1'b0;
         last_entry_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
         issued_last_ff <= 1'b0;
         scan_idx_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         slot_used_ff   <= slot_used_in;
         last_valid_ff  <= last_valid_in;
         last_entry_ff  <= last_entry_in;
         rsp_valid_ff   <= rsp_valid_in;
         pend_ff        <= pend_in;
         issued_last_ff <= issued_last_in;
         scan_idx_ff    <= scan_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      hit_mask_ff <= hit_mask_in;
      now_ff      <= now_in;
   end

   // region memory, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         region_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= region_mem[mem_addr];
      end
   end

endmodule

@@ dv/tb.sv @@
// Self-checking bench for touch_region_hit_table: a scripted opening, then random
// allocate/free/clear/sample traffic checked beat by beat against an in-bench model.
// Depends on trht_pkg and touch_region_hit_table.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import trht_pkg::*;

   localparam int SLOTS        = 32;
   localparam int RANDOM_ITEMS = 1625;
   localparam int DRAIN_CYCLES = 60;
   localparam int LIMIT_CYCLES = 600000;
   localparam int MAX_REPORTS  = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   touch_region_hit_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // table model state
   logic [11:0] box_left   [SLOTS];
   logic [11:0] box_right  [SLOTS];
   logic [11:0] box_top    [SLOTS];
   logic [11:0] box_bottom [SLOTS];
   logic [3:0]  box_events [SLOTS];
   bit          slot_busy  [SLOTS];
   bit          touch_active;
   logic [4:0]  touch_entry;

   rsp_type pending_rsp [$];
   rsp_type exp_beat;
   int      mismatches = 0;
   int      cycles     = 0;
   int      burst_left = 0;
   int      stall_mode = 0;
   int      stall_left = 0;

   // scripted opening: a beat, a repeat count and an optional hand-written result
   typedef struct {
      req_type beat;
      int      reps;
      bit      typed;
      rsp_type want;
   } script_row_type;

   script_row_type script [$];

   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("tb: errors");
         $finish;
      end
   end

   // receiver stall pattern: calm, light, heavy and long-run stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= stall_left[3];
      endcase
   end

   // model of one command; updates table state and returns the result beat
   function automatic rsp_type hit_table_step(input req_type b);
      rsp_type    r;
      int         i;
      int         free_slot;
      bit         now;
      bit         changed;
      bit         lift;
      bit         clk;
      logic [4:0] hit;
      logic [3:0] m;
      r = '0;
      case (b.cmd)
         CMD_ALLOC: begin
            free_slot = -1;
            for (i = 0; i < SLOTS; i++) begin
               if (!slot_busy[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) begin
               r.status = 1'b1;
            end else begin
               box_left[free_slot]   = b.left_x;
               box_right[free_slot]  = b.right_x;
               box_top[free_slot]    = b.top_y;
               box_bottom[free_slot] = b.bottom_y;
               box_events[free_slot] = b.event_mask;
               slot_busy[free_slot]  = 1'b1;
               r.alloc_id = free_slot[4:0];
            end
         end
         CMD_FREE: begin
            slot_busy[b.entry_id] = 1'b0;
         end
         CMD_CLEAR: begin
            for (i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
            touch_active = 1'b0;
            touch_entry  = '0;
         end
         default: begin
            // lowest live region holding the point, bounds inclusive
            now = 1'b0;
            hit = '0;
            if (b.pressed) begin
               for (i = SLOTS - 1; i >= 0; i--) begin
                  if (slot_busy[i] && box_left[i] <= b.pos_x && box_right[i] >= b.pos_x &&
                      box_top[i] <= b.pos_y && box_bottom[i] >= b.pos_y) begin
                     now = 1'b1;
                     hit = i[4:0];
                  end
               end
            end
            changed = (now != touch_active) || (now && hit != touch_entry);
            if (changed && touch_active) begin
               // old entry keeps its mask even when freed
               m    = box_events[touch_entry];
               lift = m[EV_LIFT];
               clk  = !now && m[EV_CLICK];
               r.lift_off = lift;
               r.click    = clk;
               if (lift || clk) r.old_id = touch_entry;
            end
            if (changed && now && box_events[hit][EV_START]) begin
               r.touch_start    = 1'b1;
               r.touched_id     = hit;
               r.event_x        = b.pos_x;
               r.event_y        = b.pos_y;
               r.event_pressure = b.pressure;
            end
            if (now && box_events[hit][EV_HELD]) begin
               r.held       = 1'b1;
               r.touched_id = hit;
            end
            touch_active = now;
            touch_entry  = now ? hit : 5'd0;
         end
      endcase
      return r;
   endfunction

   function automatic req_type noise_beat();
      return req_type'({$urandom(), $urandom(), $urandom()});
   endfunction

   function automatic req_type mk_alloc(input int lx, input int rx, input int ty,
                                        input int by, input logic [3:0] mask);
      req_type b;
      b = noise_beat();
      b.cmd        = CMD_ALLOC;
      b.left_x     = lx[11:0];
      b.right_x    = rx[11:0];
      b.top_y      = ty[11:0];
      b.bottom_y   = by[11:0];
      b.event_mask = mask;
      return b;
   endfunction

   function automatic req_type mk_free(input int id);
      req_type b;
      b = noise_beat();
      b.cmd      = CMD_FREE;
      b.entry_id = id[4:0];
      return b;
   endfunction

   function automatic req_type mk_clear();
      req_type b;
      b = noise_beat();
      b.cmd = CMD_CLEAR;
      return b;
   endfunction

   function automatic req_type mk_sample(input bit down, input int x, input int y,
                                         input int p);
      req_type b;
      b = noise_beat();
      b.cmd      = CMD_SAMPLE;
      b.pressed  = down;
      b.pos_x    = x[11:0];
      b.pos_y    = y[11:0];
      b.pressure = p[11:0];
      return b;
   endfunction

   function automatic void add_row(input req_type b, input int reps, input bit typed,
                                   input rsp_type want);
      script_row_type row;
      row.beat  = b;
      row.reps  = reps;
      row.typed = typed;
      row.want  = want;
      script.push_back(row);
   endfunction

   // random live slot, or -1 when the table is empty
   function automatic int pick_busy_slot();
      int i;
      int count;
      int nth;
      count = 0;
      for (i = 0; i < SLOTS; i++) if (slot_busy[i]) count++;
      if (count == 0) return -1;
      nth = $urandom_range(0, count - 1);
      for (i = 0; i < SLOTS; i++) begin
         if (slot_busy[i]) begin
            if (nth == 0) return i;
            nth--;
         end
      end
      return -1;
   endfunction

   // random traffic; phases lean toward filling, mixing or draining the table
   function automatic req_type random_beat(input int k);
      req_type b;
      int      dice;
      int      lean;
      int      alloc_share;
      int      slot;
      int      shape;
      int      w;
      int      lx;
      int      ty;
      b    = noise_beat();
      dice = $urandom_range(0, 99);
      lean = (k / 150) % 3;
      alloc_share = (lean == 0) ? 36 : (lean == 1) ? 24 : 12;
      if (dice < 5) return b;
      if (dice < 7) begin
         b.cmd = CMD_CLEAR;
      end else if (dice < 52) begin
         b.cmd     = CMD_SAMPLE;
         b.pressed = ($urandom_range(0, 9) != 0);
         slot      = pick_busy_slot();
         if (slot >= 0 && $urandom_range(0, 3) != 0) begin
            b.pos_x = 12'($urandom_range(box_right[slot], box_left[slot]));
            b.pos_y = 12'($urandom_range(box_bottom[slot], box_top[slot]));
         end
      end else if (dice < 52 + alloc_share) begin
         b.cmd = CMD_ALLOC;
         shape = $urandom_range(0, 9);
         if (shape <= 5) begin
            // small well-formed box
            lx = $urandom_range(0, 4095);
            w  = lx + $urandom_range(0, 700);
            b.left_x  = lx[11:0];
            b.right_x = (w > 4095) ? 12'hFFF : w[11:0];
            ty = $urandom_range(0, 4095);
            w  = ty + $urandom_range(0, 700);
            b.top_y    = ty[11:0];
            b.bottom_y = (w > 4095) ? 12'hFFF : w[11:0];
         end else if (shape == 6) begin
            // empty box, left above right
            lx = $urandom_range(1, 4095);
            b.left_x  = lx[11:0];
            b.right_x = 12'($urandom_range(0, lx - 1));
         end else if (shape == 7) begin
            // boxes touching the screen edges
            b.left_x   = $urandom_range(0, 1) ? 12'd0 : b.left_x;
            b.right_x  = $urandom_range(0, 1) ? 12'hFFF : b.right_x;
            b.top_y    = $urandom_range(0, 1) ? 12'd0 : b.top_y;
            b.bottom_y = $urandom_range(0, 1) ? 12'hFFF : b.bottom_y;
         end
      end else begin
         b.cmd = CMD_FREE;
         slot  = pick_busy_slot();
         if (slot >= 0 && $urandom_range(0, 3) != 0) b.entry_id = slot[4:0];
      end
      return b;
   endfunction

   // drive one beat, hold it until taken, then maybe idle between bursts
   task automatic send_beat(input req_type b, input bit typed, input rsp_type want);
      rsp_type predicted;
      int      gap;
      req_data  <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = hit_table_step(b);
      pending_rsp.push_back(typed ? want : predicted);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic check_field(input string fname, input logic [11:0] want,
                              input logic [11:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("tb: mismatch on %s: expected %0h, got %0h", fname, want, got);
      end
   endtask

   // result beat checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("tb: result beat with nothing pending: %p", rsp_data);
         end else begin
            exp_beat = pending_rsp.pop_front();
            check_field("status", 12'(exp_beat.status), 12'(rsp_data.status));
            check_field("alloc_id", 12'(exp_beat.alloc_id), 12'(rsp_data.alloc_id));
            check_field("lift_off", 12'(exp_beat.lift_off), 12'(rsp_data.lift_off));
            check_field("click", 12'(exp_beat.click), 12'(rsp_data.click));
            check_field("old_id", 12'(exp_beat.old_id), 12'(rsp_data.old_id));
            check_field("touch_start", 12'(exp_beat.touch_start),
                        12'(rsp_data.touch_start));
            check_field("held", 12'(exp_beat.held), 12'(rsp_data.held));
            check_field("touched_id", 12'(exp_beat.touched_id), 12'(rsp_data.touched_id));
            check_field("event_x", exp_beat.event_x, rsp_data.event_x);
            check_field("event_y", exp_beat.event_y, rsp_data.event_y);
            check_field("event_pressure", exp_beat.event_pressure, rsp_data.event_pressure);
         end
      end
   end

   // stimulus and verdict
   initial begin
      rsp_type w;
      int      k;
      int      r;
      for (k = 0; k < SLOTS; k++) slot_busy[k] = 1'b0;
      touch_active = 1'b0;
      touch_entry  = '0;

      // empty table after reset
      w = '0;
      add_row(mk_sample(1'b0, 4095, 4095, 4095), 1, 1'b1, w);
      add_row(mk_sample(1'b1, 0, 0, 0), 1, 1'b1, w);
      add_row(mk_clear(), 1, 1'b1, w);
      add_row(mk_free(31), 1, 1'b1, w);
      // full screen, empty box, corner box
      w = '0;
      w.alloc_id = 5'd0;
      add_row(mk_alloc(0, 4095, 0, 4095, 4'hF), 1, 1'b1, w);
      w.alloc_id = 5'd1;
      add_row(mk_alloc(100, 50, 0, 4095, 4'hF), 1, 1'b1, w);
      w.alloc_id = 5'd2;
      add_row(mk_alloc(4000, 4095, 4000, 4095, 4'hF), 1, 1'b1, w);
      // first press starts entry 0, then held
      w = '0;
      w.touch_start    = 1'b1;
      w.held           = 1'b1;
      w.touched_id     = 5'd0;
      w.event_x        = 12'hFFF;
      w.event_y        = 12'hFFF;
      w.event_pressure = 12'hFFF;
      add_row(mk_sample(1'b1, 4095, 4095, 4095), 1, 1'b1, w);
      w = '0;
      w.held       = 1'b1;
      w.touched_id = 5'd0;
      add_row(mk_sample(1'b1, 0, 0, 0), 1, 1'b1, w);
      add_row(mk_sample(1'b1, 75, 10, 99), 1, 1'b0, w);
      // freed touched entry still owns lift-off; a press outside every region gives click
      w = '0;
      add_row(mk_free(0), 1, 1'b1, w);
      add_row(mk_sample(1'b1, 4095, 4095, 1234), 1, 1'b0, w);
      add_row(mk_sample(1'b1, 75, 10, 5), 1, 1'b0, w);
      add_row(mk_sample(1'b0, 0, 0, 0), 1, 1'b0, w);
      // silent region in the lowest slot, then fill the table
      add_row(mk_alloc(0, 4095, 0, 4095, 4'h0), 1, 1'b0, w);
      add_row(mk_sample(1'b1, 10, 10, 10), 1, 1'b0, w);
      add_row(mk_sample(1'b1, 4050, 4050, 7), 1, 1'b0, w);
      add_row(mk_alloc(0, 0, 0, 0, 4'b1010), 29, 1'b0, w);
      w = '0;
      w.status = 1'b1;
      add_row(mk_alloc(0, 4095, 0, 4095, 4'hF), 1, 1'b1, w);
      // top slot reuse and hit
      w = '0;
      add_row(mk_free(31), 1, 1'b1, w);
      w.alloc_id = 5'd31;
      add_row(mk_alloc(1, 1, 1, 1, 4'b0110), 1, 1'b1, w);
      w = '0;
      add_row(mk_free(0), 1, 1'b1, w);
      add_row(mk_sample(1'b1, 1, 1, 321), 1, 1'b0, w);
      // clear drops the touch without events
      add_row(mk_clear(), 1, 1'b1, w);
      add_row(mk_sample(1'b1, 1, 1, 2), 1, 1'b1, w);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < script.size(); k++) begin
         for (r = 0; r < script[k].reps; r++)
            send_beat(script[k].beat, script[k].typed, script[k].want);
      end
      for (k = 0; k < RANDOM_ITEMS; k++) send_beat(random_beat(k), 1'b0, '0);
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

@@ touch_region_hit_table.f @@
src/trht_pkg.sv
src/touch_region_hit_table.sv
dv/tb.sv
